// ----- rtl/core/rgbamip_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbamip_pkg
// Shared types and constants of the 2x2 RGBA mipmap downsampler.
// ----------------------------------------------------------------------------
package rgbamip_pkg;

  // Configuration register indexes.
  localparam logic [7:0] RegSourceWidth  = 8'd0;
  localparam logic [7:0] RegSourceHeight = 8'd1;

  localparam int RegWidth    = 13;
  localparam int HeightLimit = 4096;
  localparam int RowWidth    = 12;

  // Four 9-bit horizontal pair sums, one per channel.
  typedef struct packed {
    logic [8:0] alpha;
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } pair_sum_t;

endpackage

// ----- rtl/core/rgbamip_line_ram.sv -----
// ----------------------------------------------------------------------------
// rgbamip_line_ram
// Single-port line store of pair sums with registered read data.
// ----------------------------------------------------------------------------
module rgbamip_line_ram
  import rgbamip_pkg::*;
#(
  parameter int Depth     = 2048,
  parameter int AddrWidth = 11
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic                 rd_en_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  pair_sum_t            wr_data_i,
  output pair_sum_t            rd_data_o
);

  pair_sum_t mem_q [Depth];
  pair_sum_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/rgba_mip_downsample_2x2.sv -----
// ----------------------------------------------------------------------------
// rgba_mip_downsample_2x2
// One level of a 2x2 box-filter mipmap downsample of a raster RGBA8 stream.
// ----------------------------------------------------------------------------
// Pipeline: the source pixel that completes a block is registered into stage one
// while the line store is read, then averaged into the output register.
// Throughput: one source pixel per cycle, single line-store port used once per
// pixel; input stalls only when stage one is full and the result is not taken.
// Reset: counters clear to the first pixel, width and height return to one;
// the line store and the held pixel are not cleared and need no sweep.
module rgba_mip_downsample_2x2
  import rgbamip_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [RegWidth-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_red_i,
  input  logic [7:0]          in_green_i,
  input  logic [7:0]          in_blue_i,
  input  logic [7:0]          in_alpha_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o,
  output logic [7:0]          out_alpha_o,
  output logic                image_done_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int LineDepth = MAX_WIDTH / 2;
  localparam int AW = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  logic [RegWidth-1:0] width_q, height_q;
  logic [CW-1:0]       col_q, col_d;
  logic [RowWidth-1:0] row_q, row_d;
  logic [31:0]         hold_q;

  logic [WW-1:0]       w_eff, ow, used_w, cidx, idx, col_inc;
  logic [RegWidth-1:0] h_eff, used_h, row_inc;
  logic                w_one, h_one;
  logic                cfg_acc, in_acc;
  logic                have_pair, act, emit_now, mem_wr, mem_rd, done_now;
  pair_sum_t           pair_now, rd_data;

  logic                s1_valid_q, s1_go;
  pair_sum_t           s1_pair_q;
  logic                s1_h_one_q, s1_done_q;

  logic                out_valid_q;
  logic [7:0]          out_r_q, out_g_q, out_b_q, out_a_q;
  logic                out_done_q;
  logic [9:0]          tot_r, tot_g, tot_b, tot_a;
  logic [9:0]          rnd_r, rnd_g, rnd_b, rnd_a;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // Effective dimensions, clamped to the supported range.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RegWidth'(1);
    end else if (32'(height_q) > 32'(HeightLimit)) begin
      h_eff = RegWidth'(HeightLimit);
    end else begin
      h_eff = height_q;
    end
    w_one  = (w_eff == WW'(1));
    h_one  = (h_eff == RegWidth'(1));
    ow     = w_one ? WW'(1) : (w_eff >> 1);
    used_w = w_one ? WW'(1) : {w_eff[WW-1:1], 1'b0};
    used_h = h_one ? RegWidth'(1) : {h_eff[RegWidth-1:1], 1'b0};
  end

  // Pair sums and line-store control for the pixel being accepted.
  always_comb begin
    in_acc = in_valid_i & in_ready_o;
    if (w_one) begin
      pair_now.red   = {in_red_i, 1'b0};
      pair_now.green = {in_green_i, 1'b0};
      pair_now.blue  = {in_blue_i, 1'b0};
      pair_now.alpha = {in_alpha_i, 1'b0};
    end else begin
      pair_now.red   = {1'b0, hold_q[7:0]}   + {1'b0, in_red_i};
      pair_now.green = {1'b0, hold_q[15:8]}  + {1'b0, in_green_i};
      pair_now.blue  = {1'b0, hold_q[23:16]} + {1'b0, in_blue_i};
      pair_now.alpha = {1'b0, hold_q[31:24]} + {1'b0, in_alpha_i};
    end
    have_pair = ({1'b0, col_q} < used_w) & (w_one | col_q[0]);
    act       = in_acc & have_pair & ({1'b0, row_q} < used_h);
    cidx      = WW'(col_q >> 1);
    if (w_one) begin
      idx = '0;
    end else if (cidx >= WW'(LineDepth)) begin
      idx = WW'(LineDepth - 1);
    end else begin
      idx = cidx;
    end
    mem_wr   = act & ~h_one & ~row_q[0];
    mem_rd   = act & ~h_one & row_q[0];
    emit_now = act & (h_one | row_q[0]);
    done_now = (idx == ow - WW'(1)) & ({1'b0, row_q} == used_h - RegWidth'(1));
  end

  // Raster position of the next source pixel.
  always_comb begin
    col_inc = {1'b0, col_q} + WW'(1);
    row_inc = {1'b0, row_q} + RegWidth'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[RowWidth-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RegWidth'(1);
      height_q <= RegWidth'(1);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_acc && (cfg_index_i == RegSourceWidth ||
                             cfg_index_i == RegSourceHeight)) begin
      if (cfg_index_i == RegSourceWidth) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Even-column pixel waiting for its right neighbor.
  always_ff @(posedge clk_i) begin
    if (in_acc && !w_one && !col_q[0] && ({1'b0, col_q} < used_w)) begin
      hold_q <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    end
  end

  rgbamip_line_ram #(
    .Depth     (LineDepth),
    .AddrWidth (AW)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .rd_en_i   (mem_rd),
    .addr_i    (AW'(idx)),
    .wr_data_i (pair_now),
    .rd_data_o (rd_data)
  );

  // Stage one holds a completed block; for two rows its stored pair sums come from the line store.
  assign s1_go      = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~s1_valid_q | s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (emit_now) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      s1_pair_q  <= pair_now;
      s1_h_one_q <= h_one;
      s1_done_q  <= done_now;
    end
  end

  always_comb begin
    if (s1_h_one_q) begin
      tot_r = {1'b0, s1_pair_q.red}   + {1'b0, s1_pair_q.red};
      tot_g = {1'b0, s1_pair_q.green} + {1'b0, s1_pair_q.green};
      tot_b = {1'b0, s1_pair_q.blue}  + {1'b0, s1_pair_q.blue};
      tot_a = {1'b0, s1_pair_q.alpha} + {1'b0, s1_pair_q.alpha};
    end else begin
      tot_r = {1'b0, s1_pair_q.red}   + {1'b0, rd_data.red};
      tot_g = {1'b0, s1_pair_q.green} + {1'b0, rd_data.green};
      tot_b = {1'b0, s1_pair_q.blue}  + {1'b0, rd_data.blue};
      tot_a = {1'b0, s1_pair_q.alpha} + {1'b0, rd_data.alpha};
    end
    rnd_r = tot_r + 10'd2;
    rnd_g = tot_g + 10'd2;
    rnd_b = tot_b + 10'd2;
    rnd_a = tot_a + 10'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_valid_q) begin
      out_r_q    <= rnd_r[9:2];
      out_g_q    <= rnd_g[9:2];
      out_b_q    <= rnd_b[9:2];
      out_a_q    <= rnd_a[9:2];
      out_done_q <= s1_done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_r_q;
  assign out_green_o  = out_g_q;
  assign out_blue_o   = out_b_q;
  assign out_alpha_o  = out_a_q;
  assign image_done_o = out_done_q;

endmodule

// ----- dv/rgba_mip_downsample_2x2_tb.sv -----
// ----------------------------------------------------------------------------
// rgba_mip_downsample_2x2_tb
// Streams RGBA8 source images of many sizes through the 2x2 downsampler.
// Every accepted pixel is also run through a local model of the box filter.
// Each result is compared field by field with the oldest predicted pixel.
// The run covers random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module rgba_mip_downsample_2x2_tb;
  import rgbamip_pkg::*;

  localparam int MaxWidth    = 4096;
  localparam int LineDepth   = MaxWidth / 2;
  localparam int RandomItems = 1450;
  localparam int HoldCycles  = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       done;
  } mip_out_t;

  typedef enum logic {RowConfig, RowPixel} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [7:0]          reg_idx;
    logic [RegWidth-1:0] reg_val;
    logic [31:0]         pixel;
    logic                typed;
    mip_out_t            want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_index_i = '0;
  logic [RegWidth-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          in_red_i = '0;
  logic [7:0]          in_green_i = '0;
  logic [7:0]          in_blue_i = '0;
  logic [7:0]          in_alpha_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          out_red_o;
  logic [7:0]          out_green_o;
  logic [7:0]          out_blue_o;
  logic [7:0]          out_alpha_o;
  logic                image_done_o;

  // Typed expectation that travels with the pixel on offer.
  logic     pin_typed = 1'b0;
  mip_out_t pin_want = '0;

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_kicks = 0;
  int hold_served = 0;
  int hold_left = 0;

  int fail_count = 0;
  int report_count = 0;
  mip_out_t mip_q [$];

  // Shadow of the block state.
  logic [RegWidth-1:0] exp_width = 1;
  logic [RegWidth-1:0] exp_height = 1;
  int unsigned         exp_col = 0;
  int unsigned         exp_row = 0;
  logic [31:0]         exp_left_px = '0;
  int unsigned         exp_pair_line [LineDepth][4];

  rgba_mip_downsample_2x2 #(
    .MAX_WIDTH(MaxWidth)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .in_alpha_i  (in_alpha_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o),
    .image_done_o(image_done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned limit);
    return (v < 1) ? 1 : ((v > limit) ? limit : v);
  endfunction

  function automatic logic [RegWidth-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return RegWidth'($urandom_range(1, 8));
    if (r < 95) return RegWidth'($urandom_range(9, 40));
    return $urandom_range(0, 1) ? '0 : '1;
  endfunction

  function automatic void write_shadow_reg(input logic [7:0] idx,
                                           input logic [RegWidth-1:0] val);
    case (idx)
      RegSourceWidth: begin
        exp_width = val;
        exp_col = 0;
        exp_row = 0;
      end
      RegSourceHeight: begin
        exp_height = val;
        exp_col = 0;
        exp_row = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // Advances the shadow state by one source pixel; returns 1 when a block completes.
  function automatic bit downsample_step(input logic [31:0] px, output mip_out_t res);
    int unsigned w, h, ow, oh, used_w, used_h, idx;
    int unsigned pair [4];
    int unsigned total [4];
    bit have_pair, emit;
    w = eff_dim(32'(exp_width), MaxWidth);
    h = eff_dim(32'(exp_height), HeightLimit);
    ow = ((w >> 1) != 0) ? (w >> 1) : 1;
    oh = ((h >> 1) != 0) ? (h >> 1) : 1;
    used_w = (w == 1) ? 1 : 2 * ow;
    used_h = (h == 1) ? 1 : 2 * oh;
    have_pair = 1'b0;
    emit = 1'b0;
    idx = 0;
    res = '0;
    if (exp_col < used_w) begin
      if (w == 1) begin
        for (int k = 0; k < 4; k++) pair[k] = 2 * 32'(px[8*k +: 8]);
        have_pair = 1'b1;
      end else if (exp_col % 2 == 0) begin
        exp_left_px = px;
      end else begin
        for (int k = 0; k < 4; k++) begin
          pair[k] = 32'(exp_left_px[8*k +: 8]) + 32'(px[8*k +: 8]);
        end
        have_pair = 1'b1;
      end
    end
    if (have_pair && exp_row < used_h) begin
      idx = (w == 1) ? 0 : (exp_col >> 1);
      if (idx >= LineDepth) idx = LineDepth - 1;
      if (h == 1) begin
        for (int k = 0; k < 4; k++) total[k] = 2 * pair[k];
        emit = 1'b1;
      end else if (exp_row % 2 == 0) begin
        for (int k = 0; k < 4; k++) exp_pair_line[idx][k] = pair[k];
      end else begin
        for (int k = 0; k < 4; k++) total[k] = exp_pair_line[idx][k] + pair[k];
        emit = 1'b1;
      end
    end
    if (emit) begin
      res.red   = 8'((total[0] + 2) >> 2);
      res.green = 8'((total[1] + 2) >> 2);
      res.blue  = 8'((total[2] + 2) >> 2);
      res.alpha = 8'((total[3] + 2) >> 2);
      res.done  = (idx == ow - 1) && (exp_row == used_h - 1);
    end
    exp_col++;
    if (exp_col >= w) begin
      exp_col = 0;
      exp_row++;
      if (exp_row >= h) exp_row = 0;
    end
    return emit;
  endfunction

  // Predicts on every accepted request and checks every accepted result.
  always @(posedge clk_i) begin : scoreboard
    mip_out_t res;
    mip_out_t got;
    mip_out_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) write_shadow_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        if (downsample_step({in_alpha_i, in_blue_i, in_green_i, in_red_i}, res)) begin
          mip_q.insert(mip_q.size(), pin_typed ? pin_want : res);
        end
      end
      if (out_valid_o && out_ready_i) begin
        got = '{out_red_o, out_green_o, out_blue_o, out_alpha_o, image_done_o};
        if (mip_q.size() == 0) begin
          fail_count++;
          if (report_count < 10) begin
            report_count++;
            $display("unexpected result: r %02h g %02h b %02h a %02h done %0b",
                     got.red, got.green, got.blue, got.alpha, got.done);
          end
        end else begin
          want = mip_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha ||
              got.done !== want.done) begin
            fail_count++;
            if (report_count < 10) begin
              report_count++;
              $display("mismatch: expected r %02h g %02h b %02h a %02h done %0b",
                       want.red, want.green, want.blue, want.alpha, want.done);
              $display("          actual   r %02h g %02h b %02h a %02h done %0b",
                       got.red, got.green, got.blue, got.alpha, got.done);
            end
          end
        end
      end
    end
  end

  // Output side: random back-pressure plus the long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_kicks != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !rx_gaps || ($urandom_range(0, 99) >= 33);
    end
  end

  task automatic send_pixel(input logic [31:0] px, input logic typed, input mip_out_t want);
    while (tx_gaps && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {in_alpha_i, in_blue_i, in_green_i, in_red_i} <= px;
    pin_typed <= typed;
    pin_want <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits until every predicted pixel is out and the pipeline has emptied.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mip_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [RegWidth-1:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t rows [$];
    logic [RegWidth-1:0] w_reg, h_reg;
    int unsigned n, sent;
    rows = '{
      '{RowPixel, 8'd0, 13'd0, 32'h0000_0000, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
      '{RowPixel, 8'd0, 13'd0, 32'hFFFF_FFFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
      '{RowPixel, 8'd0, 13'd0, 32'hA55A_C33C, 1'b1, '{8'h3C, 8'hC3, 8'h5A, 8'hA5, 1'b1}},
      '{RowConfig, RegSourceWidth, 13'd2, 32'h0, 1'b0, '0},
      '{RowConfig, RegSourceHeight, 13'd2, 32'h0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h0101_0101, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h0101_0101, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h0000_0000, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h0000_0000, 1'b1, '{8'h01, 8'h01, 8'h01, 8'h01, 1'b1}},
      '{RowConfig, RegSourceWidth, 13'd3, 32'h0, 1'b0, '0},
      '{RowConfig, RegSourceHeight, 13'd1, 32'h0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'hFF00_FF00, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h00FF_00FF, 1'b1, '{8'h80, 8'h80, 8'h80, 8'h80, 1'b1}},
      '{RowPixel, 8'd0, 13'd0, 32'h1234_5678, 1'b0, '0},
      '{RowConfig, RegSourceWidth, 13'd0, 32'h0, 1'b0, '0},
      '{RowConfig, RegSourceHeight, 13'd0, 32'h0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h8000_7F01, 1'b1, '{8'h01, 8'h7F, 8'h00, 8'h80, 1'b1}},
      '{RowConfig, RegSourceWidth, 13'd1, 32'h0, 1'b0, '0},
      '{RowConfig, RegSourceHeight, 13'd3, 32'h0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h1020_3040, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h5060_7080, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'hDEAD_BEEF, 1'b0, '0},
      '{RowConfig, RegSourceWidth, 13'd2, 32'h0, 1'b0, '0},
      '{RowConfig, RegSourceHeight, 13'd2, 32'h0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'hFFFF_FFFF, 1'b0, '0},
      // An unknown register index in the middle of an image must not restart it.
      '{RowConfig, 8'hFF, 13'h1FFF, 32'h0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'hFFFF_FFFE, 1'b0, '0},
      '{RowConfig, RegSourceWidth, 13'h1FFF, 32'h0, 1'b0, '0},
      '{RowConfig, RegSourceHeight, 13'h1FFF, 32'h0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h0F0F_0F0F, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'hF0F0_F0F0, 1'b0, '0},
      '{RowPixel, 8'd0, 13'd0, 32'h5555_AAAA, 1'b0, '0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == RowConfig) write_reg(rows[i].reg_idx, rows[i].reg_val);
      else send_pixel(rows[i].pixel, rows[i].typed, rows[i].want);
    end

    // Every pixel gives a result while the output holds off, so the input stalls.
    write_reg(RegSourceWidth, 13'd1);
    write_reg(RegSourceHeight, 13'd1);
    tx_gaps = 1'b0;
    hold_kicks <= hold_kicks + 1;
    repeat (150) send_pixel($urandom, 1'b0, '0);
    tx_gaps = 1'b1;

    sent = 0;
    while (sent < RandomItems) begin
      tx_gaps = !(sent >= 400 && sent < 800);
      rx_gaps <= !(sent >= 400 && sent < 800);
      w_reg = pick_dim();
      h_reg = pick_dim();
      if ($urandom_range(0, 1)) begin
        write_reg(RegSourceWidth, w_reg);
        write_reg(RegSourceHeight, h_reg);
      end else begin
        write_reg(RegSourceHeight, h_reg);
        write_reg(RegSourceWidth, w_reg);
      end
      if ($urandom_range(0, 7) == 0) write_reg(8'($urandom_range(2, 255)), RegWidth'($urandom));
      n = eff_dim(32'(w_reg), MaxWidth) * eff_dim(32'(h_reg), HeightLimit) *
          $urandom_range(1, 3);
      // Occasionally cut an image short; the next register write restarts it.
      if (n > 400 || $urandom_range(0, 5) == 0) n = $urandom_range(1, (n > 400) ? 400 : n);
      repeat (n) send_pixel($urandom, 1'b0, '0);
      sent += n;
    end

    drain_results();
    if (fail_count == 0 && mip_q.size() == 0) begin
      $display("rgba_mip_downsample_2x2 verification clean");
    end else begin
      $display("rgba_mip_downsample_2x2 verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rgba_mip_downsample_2x2 verification failed");
    $finish;
  end

endmodule
